/* sv/fnvds_pkg.sv */
// ----------------------------------------------------------------------------
// fnvds_pkg
// Shared constants for the FNV-1a 64-bit hash set: hash width, offset basis,
// prime split into its shifted and low parts, and the default capacity.
// ----------------------------------------------------------------------------
package fnvds_pkg;

  localparam int HASH_W = 64;
  localparam int BYTE_W = 8;

  // FNV-1a 64-bit offset basis
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

  // prime = 2^PRIME_SHIFT + PRIME_LO
  localparam int PRIME_SHIFT = 40;
  localparam int PRIME_LO_W = 9;
  localparam logic [PRIME_LO_W-1:0] PRIME_LO = 9'h1B3;

  // default number of table entries
  localparam int TABLE_ENTRIES_DEF = 64;

  // operation codes
  localparam logic OP_MARK = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

/* sv/fnvds_if.sv */
// ----------------------------------------------------------------------------
// fnvds channel interfaces
// Valid/ready channels for the string byte items and the lookup result items.
// ----------------------------------------------------------------------------
interface fnvds_in_if
  import fnvds_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, operation, byte_value, input ready);
  modport sink (input valid, operation, byte_value, output ready);
endinterface

interface fnvds_out_if
  import fnvds_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              found;
  logic              inserted;
  logic              table_full;
  logic              empty_string;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, found, inserted, table_full, empty_string, hash_value,
                  input ready);
  modport sink (input valid, found, inserted, table_full, empty_string, hash_value,
                output ready);
endinterface

/* sv/fnvds_hash_step.sv */
// ----------------------------------------------------------------------------
// fnvds_hash_step
// One FNV-1a round: xor the byte and multiply by the low part
// of the prime into a register, then add the shifted copy for the 2^40 term.
// ----------------------------------------------------------------------------
module fnvds_hash_step
  import fnvds_pkg::*;
(
  input  logic              clk,
  input  logic              start,
  input  logic [HASH_W-1:0] hash_in,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [HASH_W-1:0] hash_next
);

  localparam int PROD_W = HASH_W + PRIME_LO_W;

  logic [HASH_W-1:0] mixed;
  logic [PROD_W-1:0] prod_full;
  logic [HASH_W-1:0] mixed_q;
  logic [HASH_W-1:0] prod_q;

  // xor the byte in, narrow multiply by the low prime bits
  assign mixed = hash_in ^ {{(HASH_W-BYTE_W){1'b0}}, byte_in};
  assign prod_full = PROD_W'(mixed) * PROD_W'(PRIME_LO);

  always_ff @(posedge clk) begin
    if (start) begin
      mixed_q <= mixed;
      prod_q  <= prod_full[HASH_W-1:0];
    end
  end

  // after the register: add the 2^40 term, modulo 2^64
  assign hash_next = prod_q + {mixed_q[HASH_W-PRIME_SHIFT-1:0], {PRIME_SHIFT{1'b0}}};

endmodule

/* sv/fnv1a_hash_dedup_set.sv */
// Byte item (nonzero): accepted in idle; the next item is taken once the add state returns to idle.
// Terminator item: scans stored hashes one entry at a time through the single table
// read port and comparator, with an end check in the scan state and a done state to
// update and post the result; an empty string goes straight to the done state.
// Result waits in an output register, so bytes keep flowing while it is held.
// Synchronous reset empties the table (count to zero) and restores the basis.
// ----------------------------------------------------------------------------
// fnv1a_hash_dedup_set
// FNV-1a 64-bit string hasher with a fixed-capacity membership table.
// A zero byte ends the string and runs a mark or query against the table.
// ----------------------------------------------------------------------------
module fnv1a_hash_dedup_set
  import fnvds_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  fnvds_in_if.sink    in_ch,
  fnvds_out_if.source out_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state;
  logic [HASH_W-1:0] running_hash;
  logic              saw_byte;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  scan_idx;
  logic              hit;
  logic              op_q;
  logic [HASH_W-1:0] rd_data;
  logic [HASH_W-1:0] hash_table [TABLE_ENTRIES];

  logic              out_valid;
  logic              out_found;
  logic              out_inserted;
  logic              out_full;
  logic              out_empty;
  logic [HASH_W-1:0] out_hash;

  logic              in_take;
  logic              is_term;
  logic              step_start;
  logic [HASH_W-1:0] hash_next;
  logic              out_free;
  logic              finish;
  logic              do_mark;
  logic              do_insert;
  logic              do_full;

  assign in_ch.ready = (state == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign is_term     = (in_ch.byte_value == '0);
  assign step_start  = in_take && !is_term;

  // shared hash round unit
  fnvds_hash_step u_step (
    .clk       (clk),
    .start     (step_start),
    .hash_in   (running_hash),
    .byte_in   (in_ch.byte_value),
    .hash_next (hash_next)
  );

  // result decision at the end of the scan
  assign out_free  = !out_valid || out_ch.ready;
  assign finish    = (state == S_DONE) && out_free;
  assign do_mark   = saw_byte && (op_q == OP_MARK) && !hit;
  assign do_insert = do_mark && (entry_count != CNT_MAX);
  assign do_full   = do_mark && (entry_count == CNT_MAX);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= FNV_BASIS;
      saw_byte     <= 1'b0;
      entry_count  <= '0;
      scan_idx     <= '0;
      hit          <= 1'b0;
      op_q         <= OP_MARK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (is_term) begin
              op_q     <= in_ch.operation;
              scan_idx <= '0;
              hit      <= 1'b0;
              state    <= saw_byte ? S_SCAN : S_DONE;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          running_hash <= hash_next;
          saw_byte     <= 1'b1;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          // read of hash_table[scan_idx] lands in rd_data next cycle
          if (scan_idx == entry_count) begin
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data == running_hash) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (do_insert) begin
              entry_count <= entry_count + 1'b1;
            end
            running_hash <= FNV_BASIS;
            saw_byte     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // hash table storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (finish && do_insert) begin
      hash_table[entry_count[IDX_W-1:0]] <= running_hash;
    end
    rd_data <= hash_table[scan_idx[IDX_W-1:0]];
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (finish) begin
      out_found    <= saw_byte && hit;
      out_inserted <= do_insert;
      out_full     <= do_full;
      out_empty    <= !saw_byte;
      out_hash     <= running_hash;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.found        = out_found;
  assign out_ch.inserted     = out_inserted;
  assign out_ch.table_full   = out_full;
  assign out_ch.empty_string = out_empty;
  assign out_ch.hash_value   = out_hash;

  // count never passes capacity, scan never passes count
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (entry_count <= CNT_MAX) && (scan_idx <= entry_count))
    else $error("entry count or scan index out of range");

  // at most one outcome flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_found, out_inserted, out_full, out_empty}) <= 1)
    else $error("conflicting result flags");

  // an insert grows the table by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (finish && do_insert) |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("insert did not advance entry count");

  // a finished string leaves the hash at its starting value
  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    finish |=> (!saw_byte && running_hash == FNV_BASIS && out_valid))
    else $error("hash state not restored after terminator");

endmodule
